@@ rtl/tafa_pkg.sv @@
package tafa_pkg;

    // Input word layout: a 12-bit two's complement sample, left-justified in 16 bits.
    localparam int WORD_W    = 16;
    localparam int AXIS_W    = 12;

    // Octant numerator 450 * min(|x|,|z|) and its quotient by max(|x|,|z|).
    localparam int NUM_W     = 20;
    localparam int QUOT_W    = 9;
    localparam int OCT_SCALE = 450;

    // The divider resolves DIV_BITS quotient bits in each of DIV_STAGES stages.
    localparam int DIV_STAGES = 3;
    localparam int DIV_BITS   = 3;

    // Angle in tenths of a degree.
    localparam int ANG_W       = 10;
    localparam int TILT_W      = 12;
    localparam int MAG_W       = 11;
    localparam int RIGHT_ANGLE = 900;
    localparam logic signed [TILT_W-1:0] TILT_STRAIGHT = 12'sd1800;

    // Division by ten as a multiplication by a scaled reciprocal.
    localparam int RECIP10     = 6554;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = 24;

    // Servo angle in whole degrees.
    localparam int SERVO_W  = 8;
    localparam int WHOLE_W  = 10;
    localparam logic signed [WHOLE_W-1:0] SERVO_MID = 10'sd90;
    localparam logic signed [WHOLE_W-1:0] SERVO_MAX = 10'sd180;

    // Quadrant and octant information that travels beside the divider.
    typedef struct packed {
        logic x_neg;
        logic z_neg;
        logic x_major;
        logic zero;
    } side_t;

endpackage

@@ rtl/tafa_div.sv @@
module tafa_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tafa_pkg::NUM_W-1:0]   in_num,
    input  logic [tafa_pkg::AXIS_W-1:0]  in_den,
    input  tafa_pkg::side_t              in_side,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tafa_pkg::QUOT_W-1:0]  out_quot,
    output tafa_pkg::side_t              out_side
);
    import tafa_pkg::*;

    logic [NUM_W-1:0]  rem_reg  [DIV_STAGES];
    logic [NUM_W-1:0]  rem_next [DIV_STAGES];
    logic [QUOT_W-1:0] quot_reg  [DIV_STAGES];
    logic [QUOT_W-1:0] quot_next [DIV_STAGES];
    logic [AXIS_W-1:0] den_reg  [DIV_STAGES];
    side_t             side_reg [DIV_STAGES];
    logic              vld_reg  [DIV_STAGES];
    logic              adv      [DIV_STAGES];

    // A stage moves when it is empty or the stage after it moves.
    genvar gk;
    generate
        for (gk = 0; gk < DIV_STAGES; gk++) begin : g_adv
            if (gk == DIV_STAGES - 1) begin : g_last
                assign adv[gk] = !vld_reg[gk] || out_ready;
            end else begin : g_mid
                assign adv[gk] = !vld_reg[gk] || adv[gk + 1];
            end
        end
    endgenerate

    // Restoring division, a few quotient bits per stage, most significant first.
    always_comb begin
        logic [NUM_W:0]    r;
        logic [NUM_W:0]    dsh;
        logic [QUOT_W-1:0] q;
        logic [AXIS_W-1:0] d;
        int                i;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                r = (NUM_W + 1)'(in_num);
                q = '0;
                d = in_den;
            end else begin
                r = (NUM_W + 1)'(rem_reg[k - 1]);
                q = quot_reg[k - 1];
                d = den_reg[k - 1];
            end
            for (int b = 0; b < DIV_BITS; b++) begin
                i   = QUOT_W - 1 - DIV_BITS * k - b;
                dsh = (NUM_W + 1)'(d) << i;
                if (r >= dsh) begin
                    r    = r - dsh;
                    q[i] = 1'b1;
                end
            end
            rem_next[k]  = r[NUM_W-1:0];
            quot_next[k] = q;
        end
    end

    // Stage registers; valid bits are cleared by reset, payload is not.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (adv[k]) begin
                rem_reg[k]  <= rem_next[k];
                quot_reg[k] <= quot_next[k];
                if (k == 0) begin
                    den_reg[k]  <= in_den;
                    side_reg[k] <= in_side;
                end else begin
                    den_reg[k]  <= den_reg[k - 1];
                    side_reg[k] <= side_reg[k - 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                if (k == 0) begin
                    vld_reg[k] <= in_valid;
                end else begin
                    vld_reg[k] <= vld_reg[k - 1];
                end
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[DIV_STAGES - 1];
    assign out_quot  = quot_reg[DIV_STAGES - 1];
    assign out_side  = side_reg[DIV_STAGES - 1];

endmodule

@@ rtl/tilt_angle_from_accel_core.sv @@
// Requests pass stage 1, stage 2, the divider, stage 6 and stage 7 in order.
// Throughput: one request per cycle while m_ready is high; each stage holds its
// item only while the stage after it is full and stalled, so a bubble closes up at
// once. Stage cost is set by the three-stage divider that resolves three quotient
// bits per stage. Reset (aresetn low at a clock edge) empties every stage.
module tilt_angle_from_accel_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [tafa_pkg::WORD_W-1:0]        s_x_raw,
    input  logic [tafa_pkg::WORD_W-1:0]        s_z_raw,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [tafa_pkg::TILT_W-1:0] m_tilt_tenths,
    output logic [tafa_pkg::SERVO_W-1:0]       m_servo_deg,
    output logic                               m_clamped
);
    import tafa_pkg::*;

    // Stage 1: magnitudes, octant choice and sign bits.
    logic [AXIS_W-1:0] x_bits, z_bits, ax, az;
    logic [AXIS_W-1:0] lo_next, hi_next;
    side_t             side_next;
    logic [AXIS_W-1:0] lo_reg, hi_reg;
    side_t             p1_side_reg;
    logic              p1_vld_reg;
    logic              adv1;

    // Stage 2: octant numerator.
    logic [NUM_W-1:0]  num_next;
    logic [NUM_W-1:0]  num_reg;
    logic [AXIS_W-1:0] den_reg;
    side_t             p2_side_reg;
    logic              p2_vld_reg;
    logic              adv2;

    // Divider.
    logic              div_in_ready;
    logic              div_out_valid;
    logic [QUOT_W-1:0] div_quot;
    side_t             div_side;

    // Stage 6: signed tilt and its magnitude.
    logic [ANG_W-1:0]         ang;
    logic signed [TILT_W-1:0] ang_s;
    logic signed [TILT_W-1:0] tilt_next;
    logic signed [TILT_W-1:0] tilt_abs;
    logic signed [TILT_W-1:0] tilt_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic                     p6_vld_reg;
    logic                     adv6;

    // Stage 7: servo angle and output register.
    logic [PROD_W-1:0]         prod;
    logic [SERVO_W-1:0]        deg;
    logic signed [WHOLE_W-1:0] deg_s;
    logic signed [WHOLE_W-1:0] whole;
    logic signed [WHOLE_W-1:0] servo_s;
    logic [SERVO_W-1:0]        servo_next;
    logic                      clamped_next;
    logic                      m_valid_reg;
    logic signed [TILT_W-1:0]  m_tilt_reg;
    logic [SERVO_W-1:0]        m_servo_reg;
    logic                      m_clamped_reg;
    logic                      adv7;

    // Each stage moves when it is empty or the next stage moves.
    assign adv7    = !m_valid_reg || m_ready;
    assign adv6    = !p6_vld_reg || adv7;
    assign adv2    = !p2_vld_reg || div_in_ready;
    assign adv1    = !p1_vld_reg || adv2;
    assign s_ready = adv1;

    // Take the 12-bit samples from the top of each left-justified word and take magnitudes.
    always_comb begin
        x_bits = s_x_raw[WORD_W-1 -: AXIS_W];
        z_bits = s_z_raw[WORD_W-1 -: AXIS_W];
        ax = x_bits[AXIS_W-1] ? AXIS_W'(~x_bits + 1'b1) : x_bits;
        az = z_bits[AXIS_W-1] ? AXIS_W'(~z_bits + 1'b1) : z_bits;
        side_next.x_neg   = x_bits[AXIS_W-1];
        side_next.z_neg   = z_bits[AXIS_W-1];
        side_next.x_major = ax > az;
        side_next.zero    = (ax == '0) && (az == '0);
        lo_next = side_next.x_major ? az : ax;
        hi_next = side_next.x_major ? ax : az;
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            p1_side_reg <= side_next;
        end
    end

    // Scale the smaller magnitude for the octant law.
    assign num_next = NUM_W'(lo_reg) * NUM_W'(OCT_SCALE);

    always_ff @(posedge aclk) begin
        if (adv2) begin
            num_reg     <= num_next;
            den_reg     <= hi_reg;
            p2_side_reg <= p1_side_reg;
        end
    end

    tafa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p2_vld_reg),
        .in_ready  (div_in_ready),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .in_side   (p2_side_reg),
        .out_valid (div_out_valid),
        .out_ready (adv6),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // Fold the octant angle into its quadrant.
    always_comb begin
        ang = div_side.x_major ? ANG_W'(RIGHT_ANGLE) - ANG_W'(div_quot)
                               : ANG_W'(div_quot);
        ang_s = $signed(TILT_W'(ang));
        if (div_side.zero) begin
            tilt_next = '0;
        end else if (div_side.x_neg) begin
            tilt_next = div_side.z_neg ? ang_s - TILT_STRAIGHT : -ang_s;
        end else begin
            tilt_next = div_side.z_neg ? TILT_STRAIGHT - ang_s : ang_s;
        end
        tilt_abs = tilt_next[TILT_W-1] ? -tilt_next : tilt_next;
    end

    always_ff @(posedge aclk) begin
        if (adv6) begin
            tilt_reg <= tilt_next;
            mag_reg  <= tilt_abs[MAG_W-1:0];
        end
    end

    // Whole degrees truncated toward zero, offset to the servo center and clamped.
    always_comb begin
        prod  = PROD_W'(mag_reg) * PROD_W'(RECIP10);
        deg   = prod[RECIP_SHIFT +: SERVO_W];
        deg_s = $signed(WHOLE_W'(deg));
        whole = tilt_reg[TILT_W-1] ? -deg_s : deg_s;
        servo_s = whole + SERVO_MID;
        if (servo_s < 0) begin
            servo_next   = '0;
            clamped_next = 1'b1;
        end else if (servo_s > SERVO_MAX) begin
            servo_next   = SERVO_MAX[SERVO_W-1:0];
            clamped_next = 1'b1;
        end else begin
            servo_next   = servo_s[SERVO_W-1:0];
            clamped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv7) begin
            m_tilt_reg    <= tilt_reg;
            m_servo_reg   <= servo_next;
            m_clamped_reg <= clamped_next;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p6_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv1) begin
                p1_vld_reg <= s_valid;
            end
            if (adv2) begin
                p2_vld_reg <= p1_vld_reg;
            end
            if (adv6) begin
                p6_vld_reg <= div_out_valid;
            end
            if (adv7) begin
                m_valid_reg <= p6_vld_reg;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tilt_tenths = m_tilt_reg;
    assign m_servo_deg   = m_servo_reg;
    assign m_clamped     = m_clamped_reg;

endmodule
